/* hdl/tep_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tep_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int HEIGHT_BITS = 16;

	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int STORE_DEPTH = MAX_ROWS * (2 ** COL_W);
	localparam int RCNT_W      = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W      = $clog2(MAX_COLS + 1);
	localparam int AW          = ((HEIGHT_BITS > 16) ? HEIGHT_BITS : 16) + 2;

	localparam int IO_H_W      = 16;
	localparam int AMT_W       = 15;
	localparam int SIZE_W      = 7;
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_IDX_W   = 2;

	typedef logic signed [HEIGHT_BITS-1:0] height_t;
	typedef logic signed [AW-1:0]          wide_t;
	typedef logic [ADDR_W-1:0]             addr_t;

	localparam wide_t HMAX   = wide_t'((longint'(1) << (HEIGHT_BITS - 1)) - 1);
	localparam wide_t HMIN   = -HMAX - wide_t'(1);
	localparam wide_t IO_MAX = wide_t'(32767);
	localparam wide_t IO_MIN = -IO_MAX - wide_t'(1);

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_PASS  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ERODE = 2'd0,
		CFG_LIMIT = 2'd1,
		CFG_ROWS  = 2'd2,
		CFG_COLS  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ALU_SUB = 1'b0,
		ALU_ADD = 1'b1
	} alu_op_t;

	typedef enum logic [1:0] {
		T_IDLE = 2'd0,
		T_READ = 2'd1,
		T_PASS = 2'd2
	} top_state_t;

	typedef enum logic [3:0] {
		S_IDLE     = 4'd0,
		S_HERE_RD  = 4'd1,
		S_HERE_GET = 4'd2,
		S_NB_RD    = 4'd3,
		S_NB_GET   = 4'd4,
		S_DECIDE   = 4'd5,
		S_CELL_WR  = 4'd6,
		S_NB_WR    = 4'd7,
		S_NEXT     = 4'd8,
		S_DONE     = 4'd9
	} seq_state_t;

	typedef struct packed {
		logic    we;
		logic    re;
		addr_t   addr;
		height_t wdata;
	} ram_req_t;

	typedef struct packed {
		logic [AMT_W-1:0]  amount;
		logic [AMT_W-1:0]  limit;
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
	} pass_cfg_t;

	typedef struct packed {
		logic start;
		logic ack;
	} pass_ctl_t;

	function automatic height_t sat_height(input wide_t v);
		height_t r;
		if (v > HMAX) begin
			r = height_t'(HMAX);
		end else if (v < HMIN) begin
			r = height_t'(HMIN);
		end else begin
			r = height_t'(v);
		end
		return r;
	endfunction

	function automatic height_t sat_in(input logic signed [IO_H_W-1:0] v);
		wide_t w;
		w = wide_t'(v);
		return sat_height(w);
	endfunction

	function automatic logic signed [IO_H_W-1:0] sat_out(input height_t v);
		wide_t w;
		logic signed [IO_H_W-1:0] r;
		w = wide_t'(v);
		if (w > IO_MAX) begin
			r = IO_H_W'(IO_MAX);
		end else if (w < IO_MIN) begin
			r = IO_H_W'(IO_MIN);
		end else begin
			r = IO_H_W'(w);
		end
		return r;
	endfunction

	function automatic logic [RCNT_W-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
		logic [RCNT_W-1:0] r;
		if (v == '0) begin
			r = RCNT_W'(1);
		end else if (int'(v) > MAX_ROWS) begin
			r = RCNT_W'(MAX_ROWS);
		end else begin
			r = RCNT_W'(v);
		end
		return r;
	endfunction

	function automatic logic [CCNT_W-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
		logic [CCNT_W-1:0] r;
		if (v == '0) begin
			r = CCNT_W'(1);
		end else if (int'(v) > MAX_COLS) begin
			r = CCNT_W'(MAX_COLS);
		end else begin
			r = CCNT_W'(v);
		end
		return r;
	endfunction

	// neighbor offsets in scan order, center skipped: {dr, dc}
	function automatic logic [3:0] nb_offset(input logic [2:0] k);
		logic [3:0] r;
		case (k)
			3'd0:    r = {2'b11, 2'b11};
			3'd1:    r = {2'b11, 2'b00};
			3'd2:    r = {2'b11, 2'b01};
			3'd3:    r = {2'b00, 2'b11};
			3'd4:    r = {2'b00, 2'b01};
			3'd5:    r = {2'b01, 2'b11};
			3'd6:    r = {2'b01, 2'b00};
			3'd7:    r = {2'b01, 2'b01};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/thermal_erosion_pass_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  handshake              payload
// in       in_valid / in_stall    func, row, col, height_in
// out      out_valid / out_stall  height_out, pass_done
// cfg      cfg_we                 cfg_index, cfg_data
//
// Write and unused func: result loads at the accept edge. Read: result loads
// from the registered RAM read, in T_READ. Pass: per cell, a read of the cell,
// a read per in-grid neighbor over eight slots, a decide step, two writes when
// height moves; rows*cols cells on the single RAM port; result loads in S_DONE.
// One request at a time; in_stall is high while busy or the result is held.
// Reset clears control state, out_valid and the config registers; the height store and data registers have no reset.

module thermal_erosion_pass_unit
	import tep_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    func,
	input  wire logic [5:0]                    row,
	input  wire logic [5:0]                    col,
	input  wire logic signed [IO_H_W-1:0]      height_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [IO_H_W-1:0]           height_out,
	output logic                               pass_done,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

	top_state_t state_q, state_d;

	pass_cfg_t cfg_q;
	pass_ctl_t ctl;
	ram_req_t  port_req;
	ram_req_t  seq_req;
	ram_req_t  ram_req;
	height_t   rdata;
	logic      seq_done;

	logic      accept;
	logic      out_free;
	logic      in_store;
	logic      rd_inside_q;
	logic      load;
	logic signed [IO_H_W-1:0] load_h;
	logic      load_done;
	logic      out_valid_q;
	logic signed [IO_H_W-1:0] height_out_q;
	logic      pass_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amount <= '0;
			cfg_q.limit  <= '0;
			cfg_q.rows   <= SIZE_W'(64);
			cfg_q.cols   <= SIZE_W'(64);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ERODE: cfg_q.amount <= cfg_data[AMT_W-1:0];
				CFG_LIMIT: cfg_q.limit  <= cfg_data[AMT_W-1:0];
				CFG_ROWS:  cfg_q.rows   <= cfg_data[SIZE_W-1:0];
				CFG_COLS:  cfg_q.cols   <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tep_pass_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.rdata  (rdata),
		.req    (seq_req),
		.done   (seq_done)
	);

	tep_ram #(
		.WIDTH (HEIGHT_BITS),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.addr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			height_out_q <= load_h;
			pass_done_q  <= load_done;
		end
		if (accept) begin
			rd_inside_q <= in_store;
		end
	end

	always_comb begin
		out_free       = !out_valid_q || !out_stall;
		in_stall       = (state_q != T_IDLE) || !out_free;
		accept         = in_valid && !in_stall;
		in_store       = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
		port_req.we    = 1'b0;
		port_req.re    = 1'b0;
		port_req.addr  = {ROW_W'(row), COL_W'(col)};
		port_req.wdata = sat_in(height_in);
		ctl.start      = 1'b0;
		ctl.ack        = 1'b0;
		load           = 1'b0;
		load_h         = '0;
		load_done      = 1'b0;
		state_d        = state_q;
		case (state_q)
			T_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_WRITE: begin
							port_req.we = in_store;
							load        = 1'b1;
						end
						FUNC_READ: begin
							port_req.re = in_store;
							state_d     = T_READ;
						end
						FUNC_PASS: begin
							ctl.start = 1'b1;
							state_d   = T_PASS;
						end
						default: load = 1'b1;
					endcase
				end
			end
			T_READ: begin
				if (out_free) begin
					load    = 1'b1;
					load_h  = rd_inside_q ? sat_out(rdata) : '0;
					state_d = T_IDLE;
				end
			end
			T_PASS: begin
				if (seq_done && out_free) begin
					ctl.ack   = 1'b1;
					load      = 1'b1;
					load_done = 1'b1;
					state_d   = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
		ram_req = (state_q == T_PASS) ? seq_req : port_req;
	end

	assign out_valid  = out_valid_q;
	assign height_out = height_out_q;
	assign pass_done  = pass_done_q;

endmodule

`default_nettype wire

/* hdl/tep_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tep_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/tep_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module tep_alu
	import tep_pkg::*;
(
	input  wire alu_op_t op,
	input  wire wide_t   a,
	input  wire wide_t   b,
	output wide_t        sum,
	output height_t      sat
);

	always_comb begin
		case (op)
			ALU_ADD: sum = a + b;
			ALU_SUB: sum = a - b;
			default: sum = a - b;
		endcase
		sat = sat_height(sum);
	end

endmodule

`default_nettype wire

/* hdl/tep_pass_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module tep_pass_seq
	import tep_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pass_cfg_t cfg,
	input  wire pass_ctl_t ctl,
	input  wire height_t   rdata,
	output ram_req_t       req,
	output logic           done
);

	localparam int SR = ROW_W + 2;
	localparam int SC = COL_W + 2;

	seq_state_t state_q, state_d;

	logic [ROW_W-1:0] r_q;
	logic [COL_W-1:0] c_q;
	logic [2:0]       k_q;
	height_t          here_q;
	height_t          tgt_h_q;
	addr_t            tgt_addr_q;
	wide_t            best_q;
	logic             found_q;

	logic [RCNT_W-1:0] rows;
	logic [CCNT_W-1:0] cols;
	logic [3:0]        off;
	logic signed [SR-1:0] nr;
	logic signed [SC-1:0] nc;
	logic              nb_ok;
	addr_t             cell_addr;
	addr_t             nb_addr;
	logic              last_col;
	logic              last_row;
	logic              better;

	alu_op_t alu_op;
	wide_t   alu_a;
	wide_t   alu_b;
	wide_t   alu_sum;
	height_t alu_sat;

	tep_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum),
		.sat (alu_sat)
	);

	always_comb begin
		rows      = clamp_rows(cfg.rows);
		cols      = clamp_cols(cfg.cols);
		off       = nb_offset(k_q);
		nr        = $signed({2'b00, r_q}) + SR'($signed(off[3:2]));
		nc        = $signed({2'b00, c_q}) + SC'($signed(off[1:0]));
		nb_ok     = !nr[SR-1] && (nr < $signed(SR'(rows)))
			&& !nc[SC-1] && (nc < $signed(SC'(cols)));
		cell_addr = {r_q, c_q};
		nb_addr   = {nr[ROW_W-1:0], nc[COL_W-1:0]};
		last_col  = (CCNT_W'(c_q) == cols - CCNT_W'(1));
		last_row  = (RCNT_W'(r_q) == rows - RCNT_W'(1));
		better    = (alu_sum > best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.we    = 1'b0;
		req.re    = 1'b0;
		req.addr  = cell_addr;
		req.wdata = alu_sat;
		done      = 1'b0;
		alu_op    = ALU_SUB;
		alu_a     = wide_t'(here_q);
		alu_b     = wide_t'(rdata);
		case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					state_d = S_HERE_RD;
				end
			end
			S_HERE_RD: begin
				req.re  = 1'b1;
				state_d = S_HERE_GET;
			end
			S_HERE_GET: begin
				state_d = S_NB_RD;
			end
			S_NB_RD: begin
				req.addr = nb_addr;
				if (nb_ok) begin
					req.re  = 1'b1;
					state_d = S_NB_GET;
				end else if (k_q == 3'd7) begin
					state_d = S_DECIDE;
				end
			end
			S_NB_GET: begin
				state_d = (k_q == 3'd7) ? S_DECIDE : S_NB_RD;
			end
			S_DECIDE: begin
				state_d = (found_q && best_q > wide_t'(cfg.limit)) ? S_CELL_WR : S_NEXT;
			end
			S_CELL_WR: begin
				alu_b   = wide_t'(cfg.amount);
				req.we  = 1'b1;
				state_d = S_NB_WR;
			end
			S_NB_WR: begin
				alu_op   = ALU_ADD;
				alu_a    = wide_t'(tgt_h_q);
				alu_b    = wide_t'(cfg.amount);
				req.we   = 1'b1;
				req.addr = tgt_addr_q;
				state_d  = S_NEXT;
			end
			S_NEXT: begin
				state_d = (last_col && last_row) ? S_DONE : S_HERE_RD;
			end
			S_DONE: begin
				done = 1'b1;
				if (ctl.ack) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				r_q <= '0;
				c_q <= '0;
			end
			S_HERE_GET: begin
				here_q  <= rdata;
				best_q  <= '0;
				found_q <= 1'b0;
				k_q     <= '0;
			end
			S_NB_RD: begin
				if (!nb_ok && k_q != 3'd7) begin
					k_q <= k_q + 3'd1;
				end
			end
			S_NB_GET: begin
				if (better) begin
					best_q     <= alu_sum;
					found_q    <= 1'b1;
					tgt_addr_q <= nb_addr;
					tgt_h_q    <= rdata;
				end
				k_q <= k_q + 3'd1;
			end
			S_NEXT: begin
				if (last_col) begin
					c_q <= '0;
					r_q <= r_q + ROW_W'(1);
				end else begin
					c_q <= c_q + COL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* sim/erosion_result_checker.sv */
`timescale 1ns / 1ps

module erosion_result_checker
	import tep_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [5:0]               row,
	input  logic [5:0]               col,
	input  logic signed [IO_H_W-1:0] height_in,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [IO_H_W-1:0] height_out,
	input  logic                     pass_done,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       checked
);

	localparam int DUE_DEPTH = 16;

	typedef struct {
		logic signed [IO_H_W-1:0] height;
		logic                     done;
	} reply_t;

	height_t           grid_mem [STORE_DEPTH];
	logic [AMT_W-1:0]  amount_r;
	logic [AMT_W-1:0]  limit_r;
	logic [SIZE_W-1:0] rows_r;
	logic [SIZE_W-1:0] cols_r;
	reply_t            replies_due [DUE_DEPTH];
	int                due_rd;
	int                due_wr;
	reply_t            want;

	function automatic int span(input logic [SIZE_W-1:0] v, input int top);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > top) begin
			return top;
		end
		return int'(v);
	endfunction

	function automatic height_t clip(input int v);
		int hi;
		int lo;
		hi = (1 << (HEIGHT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return height_t'(hi);
		end
		if (v < lo) begin
			return height_t'(lo);
		end
		return height_t'(v);
	endfunction

	// raster sweep, updated in place; first steepest lower neighbor wins
	function automatic void erode_grid();
		int nrow, ncol, r, c, dr, dc, nr, nc, here, best, drop, tgt, me;
		nrow = span(rows_r, MAX_ROWS);
		ncol = span(cols_r, MAX_COLS);
		for (r = 0; r < nrow; r++) begin
			for (c = 0; c < ncol; c++) begin
				me = r * MAX_COLS + c;
				here = int'(grid_mem[me]);
				best = 0;
				tgt = -1;
				for (dr = -1; dr <= 1; dr++) begin
					for (dc = -1; dc <= 1; dc++) begin
						nr = r + dr;
						nc = c + dc;
						if ((dr != 0 || dc != 0) && nr >= 0 && nr < nrow && nc >= 0 && nc < ncol) begin
							drop = here - int'(grid_mem[nr * MAX_COLS + nc]);
							if (drop > best) begin
								best = drop;
								tgt = nr * MAX_COLS + nc;
							end
						end
					end
				end
				if (tgt >= 0 && best > int'(limit_r)) begin
					grid_mem[me] = clip(here - int'(amount_r));
					grid_mem[tgt] = clip(int'(grid_mem[tgt]) + int'(amount_r));
				end
			end
		end
	endfunction

	function automatic reply_t predict_reply(input logic [1:0] code, input logic [5:0] r,
		input logic [5:0] c, input logic signed [IO_H_W-1:0] h);
		reply_t rep;
		int     at;
		rep.height = '0;
		rep.done = 1'b0;
		at = int'(r) * MAX_COLS + int'(c);
		case (code)
			FUNC_WRITE: begin
				grid_mem[at] = clip(int'(h));
			end
			FUNC_READ: begin
				rep.height = IO_H_W'(grid_mem[at]);
			end
			FUNC_PASS: begin
				erode_grid();
				rep.done = 1'b1;
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_r <= '0;
			limit_r <= '0;
			rows_r <= SIZE_W'(MAX_ROWS);
			cols_r <= SIZE_W'(MAX_COLS);
			due_rd = 0;
			due_wr = 0;
			pending <= 0;
			fail_count = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ERODE: amount_r <= cfg_data[AMT_W-1:0];
					CFG_LIMIT: limit_r <= cfg_data[AMT_W-1:0];
					CFG_ROWS:  rows_r <= cfg_data[SIZE_W-1:0];
					CFG_COLS:  cols_r <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				checked++;
				if (due_wr == due_rd) begin
					$error("result with no request outstanding: height_out %0d, pass_done %0b",
						height_out, pass_done);
					fail_count++;
				end else begin
					want = replies_due[due_rd % DUE_DEPTH];
					due_rd++;
					if (height_out !== want.height) begin
						$error("height_out: expected %0d, got %0d", want.height, height_out);
						fail_count++;
					end
					if (pass_done !== want.done) begin
						$error("pass_done: expected %0b, got %0b", want.done, pass_done);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				replies_due[due_wr % DUE_DEPTH] = predict_reply(func, row, col, height_in);
				due_wr++;
			end
			pending <= due_wr - due_rd;
		end
	end

endmodule

/* sim/thermal_erosion_pass_unit_test.sv */
`timescale 1ns / 1ps

module thermal_erosion_pass_unit_test;
	import tep_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 950;
	localparam int PAD_W        = CFG_DATA_W - SIZE_W;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic [1:0]               func = FUNC_WRITE;
	logic [5:0]               row = '0;
	logic [5:0]               col = '0;
	logic signed [IO_H_W-1:0] height_in = '0;
	logic                     out_stall = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = CFG_ERODE;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_stall;
	logic                     out_valid;
	logic signed [IO_H_W-1:0] height_out;
	logic                     pass_done;

	int   fail_count;
	int   pending;
	int   checked;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic hold_trig = 1'b0;
	int   hold_left = 0;
	int   cycles = 0;
	bit   filled [MAX_ROWS][MAX_COLS];
	int   grid_rows = MAX_ROWS;
	int   grid_cols = MAX_COLS;
	int   n_write = 0;
	int   n_read = 0;
	int   n_pass = 0;
	int   n_unused = 0;
	int   swept = 0;

	thermal_erosion_pass_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row        (row),
		.col        (col),
		.height_in  (height_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.height_out (height_out),
		.pass_done  (pass_done),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	erosion_result_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row        (row),
		.col        (col),
		.height_in  (height_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.height_out (height_out),
		.pass_done  (pass_done),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Verification failed");
			$finish;
		end
	end

	// output side: random stall, or a long hold once triggered
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_trig) begin
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	function automatic int eff_size(input logic [CFG_DATA_W-1:0] v, input int top);
		if (v[SIZE_W-1:0] == '0) begin
			return 1;
		end
		if (int'(v[SIZE_W-1:0]) > top) begin
			return top;
		end
		return int'(v[SIZE_W-1:0]);
	endfunction

	// size register word with junk above the 7 live bits
	function automatic logic [CFG_DATA_W-1:0] size_word(input int v);
		return {PAD_W'($urandom), SIZE_W'(v)};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_level();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return CFG_DATA_W'($urandom_range(255));
			3: return CFG_DATA_W'($urandom_range(4095));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [IO_H_W-1:0] rand_height();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return '0;
					default: return '1;
				endcase
			end
			1: return IO_H_W'($urandom);
			default: return IO_H_W'($urandom_range(4095) - 2048);
		endcase
	endfunction

	task automatic send_req(input logic [1:0] code, input int r, input int c,
		input logic signed [IO_H_W-1:0] h);
		int gap;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= code;
		row <= 6'(r);
		col <= 6'(c);
		height_in <= h;
		do @(posedge clk); while (in_stall);
		case (code)
			FUNC_WRITE: n_write++;
			FUNC_READ:  n_read++;
			FUNC_PASS:  n_pass++;
			default:    n_unused++;
		endcase
	endtask

	task automatic put_cell(input int r, input int c, input logic signed [IO_H_W-1:0] h);
		send_req(FUNC_WRITE, r, c, h);
		filled[r][c] = 1'b1;
	endtask

	task automatic sweep();
		send_req(FUNC_PASS, $urandom_range(63), $urandom_range(63), rand_height());
		swept += grid_rows * grid_cols;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic program_grid(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] l,
		input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ERODE;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data <= l;
		@(posedge clk);
		cfg_index <= CFG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_rows = eff_size(r, MAX_ROWS);
		grid_cols = eff_size(c, MAX_COLS);
	endtask

	task automatic fill_grid();
		int r;
		int c;
		for (r = 0; r < grid_rows; r++) begin
			for (c = 0; c < grid_cols; c++) begin
				if (!filled[r][c]) begin
					put_cell(r, c, rand_height());
				end
			end
		end
	endtask

	task automatic read_some();
		int r;
		int c;
		r = $urandom_range(63);
		c = $urandom_range(63);
		if (!filled[r][c]) begin
			r = $urandom_range(grid_rows - 1);
			c = $urandom_range(grid_cols - 1);
		end
		send_req(FUNC_READ, r, c, rand_height());
	endtask

	task automatic run_round(input int idx);
		int pick;
		int body;
		int i;
		logic [CFG_DATA_W-1:0] rw;
		logic [CFG_DATA_W-1:0] cw;
		if (idx < 2 || $urandom_range(2) == 0) begin
			if (idx == 0) begin
				rw = size_word(127);
				cw = size_word(1);
			end else if (idx == 1) begin
				rw = size_word(0);
				cw = size_word($urandom_range(64, 127));
			end else if ($urandom_range(5) == 0) begin
				if ($urandom_range(1) == 1) begin
					rw = size_word($urandom_range(127));
					cw = size_word($urandom_range(2));
				end else begin
					rw = size_word($urandom_range(2));
					cw = size_word($urandom_range(127));
				end
			end else begin
				rw = size_word($urandom_range(1, 6));
				cw = size_word($urandom_range(1, 6));
			end
			drain();
			program_grid(rand_level(), rand_level(), rw, cw);
		end
		fill_grid();
		// long output hold while requests keep coming
		if (idx == 3) begin
			in_valid <= 1'b0;
			hold_trig <= 1'b1;
			@(posedge clk);
			hold_trig <= 1'b0;
		end
		body = $urandom_range(4, 16);
		for (i = 0; i < body; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				if ($urandom_range(9) < 6) begin
					put_cell($urandom_range(grid_rows - 1), $urandom_range(grid_cols - 1),
						rand_height());
				end else begin
					put_cell($urandom_range(63), $urandom_range(63), rand_height());
				end
			end else if (pick < 82) begin
				read_some();
			end else if (pick < 92) begin
				sweep();
			end else begin
				send_req(FUNC_UNUSED, $urandom_range(63), $urandom_range(63), rand_height());
			end
		end
		sweep();
		repeat ($urandom_range(2, 4)) read_some();
	endtask

	initial begin
		int p;
		int round_idx;
		int phase_start;
		int r;
		int c;
		round_idx = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single cell grid from zero sizes, full amount, no threshold
		program_grid('1, '0, size_word(0), size_word(0));
		put_cell(0, 0, 16'sh7fff);
		send_req(FUNC_READ, 0, 0, '0);
		sweep();
		send_req(FUNC_READ, 0, 0, '1);
		send_req(FUNC_UNUSED, 63, 63, 16'sh8000);
		put_cell(63, 63, 16'sh8000);
		send_req(FUNC_READ, 63, 63, 16'sh7fff);
		drain();

		// 2x2 with a tie between two lowest neighbors and saturating moves
		program_grid('1, '0, size_word(2), size_word(2));
		put_cell(0, 0, 16'sh7fff);
		put_cell(0, 1, 16'sh8000);
		put_cell(1, 0, '0);
		put_cell(1, 1, 16'sh8000);
		sweep();
		for (r = 0; r < 2; r++) begin
			for (c = 0; c < 2; c++) begin
				send_req(FUNC_READ, r, c, '0);
			end
		end
		drain();

		// largest limit, which only a drop above 32767 passes; here a full-scale drop
		program_grid(CFG_DATA_W'(1), '1, size_word(1), size_word(2));
		put_cell(0, 0, 16'sh7fff);
		put_cell(0, 1, 16'sh8000);
		sweep();
		send_req(FUNC_READ, 0, 0, '0);
		send_req(FUNC_READ, 0, 1, '0);

		for (p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 14;
					rx_idle_pct = 82;
				end
				1: begin
					tx_idle_pct = 82;
					rx_idle_pct = 14;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			phase_start = n_write + n_read + n_pass;
			while (n_write + n_read + n_pass - phase_start < RANDOM_ITEMS / 3) begin
				run_round(round_idx);
				round_idx++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d writes, %0d reads, %0d erosion passes over %0d cells, %0d unused codes",
			n_write, n_read, n_pass, swept, n_unused);
		$display("%0d results compared across %0d grid rounds and three idle mixes",
			checked, round_idx);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/tep_pkg.sv
hdl/tep_ram.sv
hdl/tep_alu.sv
hdl/tep_pass_seq.sv
hdl/thermal_erosion_pass_unit.sv
sim/erosion_result_checker.sv
sim/thermal_erosion_pass_unit_test.sv
